// ===== rtl/core/websocket_frame_receiver_defines.svh =====
// assertion macros shared by the receiver modules
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define WSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WSR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WSR_ASSERT(lbl, prop, msg)
`define WSR_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/wsr_pkg.sv =====
package wsr_pkg;

  // size of the chunk buffer in bytes
  localparam int MAX_FRAME_BYTES = 4096;

  localparam int CFG_W   = 13;
  localparam int LEN_W   = 13;
  localparam int CNT_W   = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic CMD_BYTE      = 1'b0;
  localparam logic CMD_LINK_LOST = 1'b1;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [7:0] RSV_MASK   = 8'b0111_0000;
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_LEN16,
    PH_LEN64,
    PH_PAYLOAD,
    PH_DONE,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA  = 3'd0,
    ST_PING  = 3'd1,
    ST_PONG  = 3'd2,
    ST_CLOSE = 3'd3,
    ST_ERROR = 3'd4,
    ST_LINK  = 3'd5
  } status_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    status_t          status;
    logic             msg_fin;
    logic [1:0]       msg_opcode;
    logic [LEN_W-1:0] frame_length;
    logic             run_last;
  } res_t;

  // results written into the output queue in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== rtl/core/wsr_parser.sv =====
`include "websocket_frame_receiver_defines.svh"

module wsr_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_chunk_end,
  input  logic                      cfg_wr_en,
  input  logic [wsr_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      space_ok,
  output wsr_pkg::push_t            push
);

  logic                      item_vld_r;
  logic                      item_cmd_r;
  logic [7:0]                item_byte_r;
  logic                      item_end_r;
  logic [wsr_pkg::CFG_W-1:0] max_payload_r;

  wsr_pkg::phase_t           phase_r, phase_nxt;
  logic                      frame_fin_r, frame_fin_nxt;
  logic [3:0]                frame_opcode_r, frame_opcode_nxt;
  logic [31:0]               payload_len_r, payload_len_nxt;
  logic [wsr_pkg::LEN_W-1:0] payload_count_r, payload_count_nxt;
  logic [wsr_pkg::CNT_W-1:0] chunk_count_r, chunk_count_nxt;
  logic                      error_seen_r, error_seen_nxt;
  logic                      last_fin_r, last_fin_nxt;
  logic [1:0]                last_opcode_r, last_opcode_nxt;

  logic                      take;
  logic [wsr_pkg::CFG_W-1:0] limit;
  logic [wsr_pkg::CNT_W-1:0] cc_inc;

  assign take     = item_vld_r && space_ok;
  assign in_stall = item_vld_r && !space_ok;
  assign limit    = (32'(max_payload_r) > 32'(wsr_pkg::MAX_FRAME_BYTES))
                  ? wsr_pkg::CFG_W'(wsr_pkg::MAX_FRAME_BYTES) : max_payload_r;
  assign cc_inc   = (chunk_count_r != wsr_pkg::CNT_MAX)
                  ? chunk_count_r + wsr_pkg::CNT_W'(1) : chunk_count_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      item_cmd_r  <= in_cmd;
      item_byte_r <= in_rx_byte;
      item_end_r  <= in_chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsr_pkg::CFG_W'(4096);
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= wsr_pkg::PH_HDR0;
      frame_fin_r     <= 1'b0;
      frame_opcode_r  <= '0;
      payload_len_r   <= '0;
      payload_count_r <= '0;
      chunk_count_r   <= '0;
      error_seen_r    <= 1'b0;
      last_fin_r      <= 1'b1;
      last_opcode_r   <= '0;
    end else begin
      phase_r         <= phase_nxt;
      frame_fin_r     <= frame_fin_nxt;
      frame_opcode_r  <= frame_opcode_nxt;
      payload_len_r   <= payload_len_nxt;
      payload_count_r <= payload_count_nxt;
      chunk_count_r   <= chunk_count_nxt;
      error_seen_r    <= error_seen_nxt;
      last_fin_r      <= last_fin_nxt;
      last_opcode_r   <= last_opcode_nxt;
    end
  end

  always_comb begin
    logic                      err;
    logic                      hdr_done;
    logic                      op_ok;
    wsr_pkg::res_t             st;

    phase_nxt         = phase_r;
    frame_fin_nxt     = frame_fin_r;
    frame_opcode_nxt  = frame_opcode_r;
    payload_len_nxt   = payload_len_r;
    payload_count_nxt = payload_count_r;
    chunk_count_nxt   = chunk_count_r;
    error_seen_nxt    = error_seen_r;
    last_fin_nxt      = last_fin_r;
    last_opcode_nxt   = last_opcode_r;
    push              = '0;
    err               = 1'b0;
    hdr_done          = 1'b0;
    st                = '0;
    op_ok = (item_byte_r[3:0] <= wsr_pkg::OP_BIN)
         || (item_byte_r[3:0] >= wsr_pkg::OP_CLOSE && item_byte_r[3:0] <= wsr_pkg::OP_PONG);

    if (take) begin
      if (item_cmd_r == wsr_pkg::CMD_LINK_LOST) begin
        phase_nxt         = wsr_pkg::PH_HDR0;
        frame_fin_nxt     = 1'b0;
        frame_opcode_nxt  = '0;
        payload_len_nxt   = '0;
        payload_count_nxt = '0;
        chunk_count_nxt   = '0;
        error_seen_nxt    = 1'b0;
        last_fin_nxt      = 1'b1;
        last_opcode_nxt   = '0;
        push.cnt          = 2'd1;
        push.r0.kind      = wsr_pkg::KIND_STATUS;
        push.r0.status    = wsr_pkg::ST_LINK;
        push.r0.run_last  = 1'b1;
      end else begin
        chunk_count_nxt = cc_inc;
        case (phase_r)
          wsr_pkg::PH_HDR0: begin
            frame_fin_nxt    = item_byte_r[7];
            frame_opcode_nxt = item_byte_r[3:0];
            if ((item_byte_r & wsr_pkg::RSV_MASK) != 8'd0) begin
              err = 1'b1;
            end else if (!op_ok) begin
              err = 1'b1;
            end else if ((item_byte_r[3:0] == wsr_pkg::OP_TEXT
                       || item_byte_r[3:0] == wsr_pkg::OP_BIN) && !last_fin_r) begin
              err = 1'b1;
            end else begin
              phase_nxt = wsr_pkg::PH_HDR1;
            end
          end
          wsr_pkg::PH_HDR1: begin
            if (item_byte_r[7]) begin
              err = 1'b1;
            end else begin
              payload_len_nxt   = '0;
              payload_count_nxt = '0;
              if (item_byte_r[6:0] == wsr_pkg::LEN_CODE16) begin
                phase_nxt = wsr_pkg::PH_LEN16;
              end else if (item_byte_r[6:0] == wsr_pkg::LEN_CODE64) begin
                phase_nxt = wsr_pkg::PH_LEN64;
              end else begin
                payload_len_nxt = 32'(item_byte_r[6:0]);
                hdr_done        = 1'b1;
              end
            end
          end
          wsr_pkg::PH_LEN16: begin
            payload_len_nxt   = {16'd0, payload_len_r[7:0], item_byte_r};
            payload_count_nxt = payload_count_r + wsr_pkg::LEN_W'(1);
            if (payload_count_nxt >= wsr_pkg::LEN_W'(2)) begin
              hdr_done = 1'b1;
            end
          end
          wsr_pkg::PH_LEN64: begin
            // the upper four length bytes must be zero
            if (payload_count_r < wsr_pkg::LEN_W'(4) && item_byte_r != 8'd0) begin
              err = 1'b1;
            end else begin
              if (payload_count_r >= wsr_pkg::LEN_W'(4)) begin
                payload_len_nxt = {payload_len_r[23:0], item_byte_r};
              end
              payload_count_nxt = payload_count_r + wsr_pkg::LEN_W'(1);
              if (payload_count_nxt >= wsr_pkg::LEN_W'(8)) begin
                hdr_done = 1'b1;
              end
            end
          end
          wsr_pkg::PH_PAYLOAD: begin
            push.cnt             = 2'd1;
            push.r0.kind         = wsr_pkg::KIND_BYTE;
            push.r0.payload_byte = item_byte_r;
            payload_count_nxt    = payload_count_r + wsr_pkg::LEN_W'(1);
            if (payload_count_nxt >= payload_len_r[wsr_pkg::LEN_W-1:0]) begin
              phase_nxt = wsr_pkg::PH_DONE;
            end
          end
          default: begin
          end
        endcase

        if (hdr_done) begin
          payload_count_nxt = '0;
          if (payload_len_nxt > 32'(limit)) begin
            err = 1'b1;
          end else if (payload_len_nxt != 32'd0) begin
            phase_nxt = wsr_pkg::PH_PAYLOAD;
          end else begin
            phase_nxt = wsr_pkg::PH_DONE;
          end
        end
        if (err) begin
          error_seen_nxt = 1'b1;
          phase_nxt      = wsr_pkg::PH_DRAIN;
        end

        if (item_end_r) begin
          st.kind     = wsr_pkg::KIND_STATUS;
          st.run_last = 1'b1;
          if (error_seen_nxt || phase_nxt != wsr_pkg::PH_DONE || cc_inc > limit) begin
            st.status = wsr_pkg::ST_ERROR;
          end else if (frame_opcode_nxt == wsr_pkg::OP_CLOSE) begin
            st.status = wsr_pkg::ST_CLOSE;
          end else if (frame_opcode_nxt == wsr_pkg::OP_PING) begin
            st.status = wsr_pkg::ST_PING;
          end else if (frame_opcode_nxt == wsr_pkg::OP_PONG) begin
            st.status = wsr_pkg::ST_PONG;
          end else begin
            if (frame_opcode_nxt != wsr_pkg::OP_CONT) begin
              last_opcode_nxt = frame_opcode_nxt[1:0];
            end
            last_fin_nxt    = frame_fin_nxt;
            st.status       = wsr_pkg::ST_DATA;
            st.msg_fin      = last_fin_nxt;
            st.msg_opcode   = last_opcode_nxt;
            st.frame_length = payload_len_nxt[wsr_pkg::LEN_W-1:0];
          end
          if (push.cnt == 2'd1) begin
            push.cnt = 2'd2;
            push.r1  = st;
          end else begin
            push.cnt = 2'd1;
            push.r0  = st;
          end
          phase_nxt         = wsr_pkg::PH_HDR0;
          frame_fin_nxt     = 1'b0;
          frame_opcode_nxt  = '0;
          payload_len_nxt   = '0;
          payload_count_nxt = '0;
          chunk_count_nxt   = '0;
          error_seen_nxt    = 1'b0;
        end
      end
    end
  end

  `WSR_NEVER(a_err_drain, error_seen_r && phase_r != wsr_pkg::PH_DRAIN, "error without drain")
  `WSR_ASSERT(a_end_rearm, take && item_end_r |=> phase_r == wsr_pkg::PH_HDR0 && chunk_count_r == '0, "chunk end did not rearm")
  `WSR_ASSERT(a_link_clear, take && item_cmd_r == wsr_pkg::CMD_LINK_LOST |=> last_fin_r && !error_seen_r, "link lost did not clear")

endmodule

// ===== rtl/core/wsr_out_fifo.sv =====
`include "websocket_frame_receiver_defines.svh"

module wsr_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsr_pkg::push_t        push,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wsr_pkg::res_t         head
);

  wsr_pkg::res_t                mem_r [wsr_pkg::FIFO_DEPTH];
  logic [wsr_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [wsr_pkg::FIFO_AW:0]    count_r;
  logic                         pop;

  // room for the worst case of two results per item
  assign space_ok  = count_r <= (wsr_pkg::FIFO_AW+1)'(wsr_pkg::FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + wsr_pkg::FIFO_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + wsr_pkg::FIFO_AW'(push.cnt);
      rd_ptr_r <= rd_ptr_r + wsr_pkg::FIFO_AW'(pop);
      count_r  <= count_r + (wsr_pkg::FIFO_AW+1)'(push.cnt)
                          - (wsr_pkg::FIFO_AW+1)'(pop);
    end
  end

  `WSR_NEVER(a_no_overflow, 32'(push.cnt) + 32'(count_r) > wsr_pkg::FIFO_DEPTH, "queue overflow")
  `WSR_NEVER(a_count_range, 32'(count_r) > wsr_pkg::FIFO_DEPTH, "queue count out of range")

endmodule

// ===== rtl/core/websocket_frame_receiver.sv =====
// websocket frame receiver: takes one received chunk a byte per item, expecting
// exactly one unmasked server frame in it, and sends payload bytes out as they
// arrive followed by one status item (data, ping, pong, close, error) on the
// chunk's last byte; a link-lost item gives a link-lost status and clears all
// parser state except max_payload. header checks: reserved bits, mask bit,
// opcode set, fragmentation order, zero upper length word, payload length and
// chunk size against min(max_payload, buffer size). one item is taken per
// cycle: the parser updates its registers in a single pass from the input
// register and writes one or two results into a four-entry output queue; the
// input side stalls only while that queue has fewer than two free entries, so
// the sustained rate is one item per cycle unless out_stall holds results back
// or a chunk's last payload byte and its status both leave in the same item.
// the user must write max_payload through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this.
module websocket_frame_receiver (
  input  logic                      clk,
  input  logic                      rst_n,
  // item in
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_chunk_end,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [wsr_pkg::CFG_W-1:0] cfg_wr_data,
  // result item out
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic [7:0]                out_payload_byte,
  output logic [2:0]                out_status,
  output logic                      out_msg_fin,
  output logic [1:0]                out_msg_opcode,
  output logic [wsr_pkg::LEN_W-1:0] out_frame_length,
  output logic                      out_run_last
);

  wsr_pkg::push_t push;
  wsr_pkg::res_t  head;
  logic           space_ok;

  // header/payload parser with its input register
  wsr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_rx_byte   (in_rx_byte),
    .in_chunk_end (in_chunk_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .space_ok     (space_ok),
    .push         (push)
  );

  // result queue decouples the two sides
  wsr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind         = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_status       = head.status;
  assign out_msg_fin      = head.msg_fin;
  assign out_msg_opcode   = head.msg_opcode;
  assign out_frame_length = head.frame_length;
  assign out_run_last     = head.run_last;

endmodule
